@@ rtl/packet_deframer_with_sum_check_macros.svh @@
// Assertion macros shared by the frame deframer RTL files.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef PACKET_DEFRAMER_WITH_SUM_CHECK_MACROS_SVH
`define PACKET_DEFRAMER_WITH_SUM_CHECK_MACROS_SVH
`ifndef ASSERT_OFF
`define PDFSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("pdfsc assertion failed");
`define PDFSC_ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pdfsc assertion failed");
`else
`define PDFSC_ASSERT(lbl, clk, rstn, prop)
`define PDFSC_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

@@ rtl/pdfsc_pkg.sv @@
// Shared types and constants of the start-byte frame deframer.
// Used by pdfsc_frame_state and packet_deframer_with_sum_check; no dependencies.
package pdfsc_pkg;

  localparam int BYTE_W = 8;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_START_ERR = 2'd1;
  localparam logic [1:0] STATUS_CHECK_ERR = 2'd2;

  typedef struct packed {
    logic        done;
    logic [15:0] packet_id;
    logic [15:0] packet_type;
    logic [31:0] payload_word;
    logic [1:0]  status;
  } frame_res_t;

endpackage

@@ rtl/pdfsc_frame_state.sv @@
// Per-frame state of the deframer: byte position, running sum, start match and
// the collected field bytes. Depends on pdfsc_pkg and the assertion macro header.
`include "packet_deframer_with_sum_check_macros.svh"

module pdfsc_frame_state #(
  parameter int PAYLOAD_BYTES = 4,
  parameter int FRAME_BYTES   = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    byte_vld,
  input  logic [7:0]              rx_byte,
  input  logic [7:0]              start_byte,
  output pdfsc_pkg::frame_res_t   res
);

  localparam int POS_W   = $clog2(FRAME_BYTES);
  localparam int LAST    = FRAME_BYTES - 2;
  localparam int SHIFT_W = pdfsc_pkg::BYTE_W * LAST;
  localparam logic [POS_W-1:0] CHECK_POS = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic               matched_r, matched_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic               is_check;
  logic [7:0]         fb [1:8];
  logic [31:0]        payload_w;

  assign is_check = (pos_r >= CHECK_POS);

  always_comb begin
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    matched_nxt = matched_r;
    shift_nxt   = shift_r;
    if (byte_vld) begin
      if (is_check) begin
        pos_nxt     = '0;
        sum_nxt     = '0;
        matched_nxt = 1'b0;
        shift_nxt   = '0;
      end else begin
        if (pos_r == '0) begin
          matched_nxt = (rx_byte == start_byte);
        end else begin
          shift_nxt = {shift_r[SHIFT_W-pdfsc_pkg::BYTE_W-1:0], rx_byte};
        end
        sum_nxt = sum_r + rx_byte;
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      sum_r     <= '0;
      matched_r <= 1'b0;
      shift_r   <= '0;
    end else begin
      pos_r     <= pos_nxt;
      sum_r     <= sum_nxt;
      matched_r <= matched_nxt;
      shift_r   <= shift_nxt;
    end
  end

  // Frame byte k sits in the shift register by its distance from the last field byte.
  for (genvar k = 1; k <= 8; k++) begin : g_fb
    if (k <= LAST) begin : g_in
      assign fb[k] = shift_r[pdfsc_pkg::BYTE_W*(LAST-k) +: pdfsc_pkg::BYTE_W];
    end else begin : g_out
      assign fb[k] = '0;
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_pay
    if (j < PAYLOAD_BYTES) begin : g_used
      assign payload_w[8*j +: 8] = fb[4 + PAYLOAD_BYTES - j];
    end else begin : g_zero
      assign payload_w[8*j +: 8] = '0;
    end
  end

  always_comb begin
    res.done         = byte_vld && is_check;
    res.packet_id    = {fb[1], fb[2]};
    res.packet_type  = {fb[3], fb[4]};
    res.payload_word = payload_w;
    if (!matched_r) begin
      res.status = pdfsc_pkg::STATUS_START_ERR;
    end else if (rx_byte != sum_r) begin
      res.status = pdfsc_pkg::STATUS_CHECK_ERR;
    end else begin
      res.status = pdfsc_pkg::STATUS_OK;
    end
  end

  `PDFSC_ASSERT(a_pos_range, clk, rst_n, pos_r <= CHECK_POS)
  `PDFSC_ASSERT(a_frame_restart, clk, rst_n,
    (byte_vld && is_check) |=> (pos_r == '0 && sum_r == '0 && !matched_r))
  `PDFSC_ASSERT(a_pos_step, clk, rst_n,
    (byte_vld && !is_check) |=> (pos_r == $past(pos_r) + 1'b1))

endmodule

@@ rtl/packet_deframer_with_sum_check.sv @@
// Channel  | Dir | Content
// in_      | in  | tdata[7:0] = rx_byte
// out_     | out | tdata[15:0] id, [31:16] type, [63:32] payload, [65:64] status
// cfg_     | in  | wr_data[7:0] = start_byte, written when wr_en is high
// A byte is taken when in_tvalid and in_tready are high; a result appears the cycle after
// the check byte is accepted and is held in the output register until taken.
// The input stalls only while a result is held and out_tready is low.
// Synchronous active-low reset clears the frame state and the start byte.
// Top level of the deframer; depends on pdfsc_pkg, pdfsc_frame_state and the macro header.
`include "packet_deframer_with_sum_check_macros.svh"

module packet_deframer_with_sum_check #(
  parameter int PAYLOAD_BYTES = 4,
  parameter int FRAME_BYTES   = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata    // packet_id, packet_type, payload_word, status
);

  logic [7:0]            start_byte_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [65:0]           out_data_r;
  logic                  in_fire;
  pdfsc_pkg::frame_res_t res;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  pdfsc_frame_state #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .FRAME_BYTES   (FRAME_BYTES)
  ) u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_vld   (in_fire),
    .rx_byte    (in_tdata),
    .start_byte (start_byte_r),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_byte_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      out_data_r <= {res.status, res.payload_word, res.packet_type, res.packet_id};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

  `PDFSC_ASSERT(a_status_legal, clk, rst_n, out_valid_r |-> (out_data_r[65:64] != 2'd3))
  `PDFSC_ASSERT(a_done_shows, clk, rst_n, res.done |=> out_valid_r)
  `PDFSC_ASSERT(a_rose_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(res.done))

endmodule
